>>> hdl/wcs_pkg.sv
// wcs_pkg: shared types, codes and constants of the weighted category sampler
// used by wcs_alu, wcs_seq and the top level; no dependencies
`default_nettype none

package wcs_pkg;

  localparam int MAX_CATEGORIES = 64;
  localparam int IDX_W          = $clog2(MAX_CATEGORIES);
  localparam int CNT_W          = $clog2(MAX_CATEGORIES + 1);
  localparam int DATA_W         = 32;
  localparam int MODE_W         = 2;
  localparam int COUNT_W        = 7;
  localparam int OPCODE_W       = 2;
  localparam int ENTRY_W        = 6;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WR_CUM = 2'd0,
    OP_WR_WGT = 2'd1,
    OP_SAMPLE = 2'd2
  } opcode_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIRST = 2'd0,
    MODE_INIT  = 2'd1,
    MODE_TRACK = 2'd2
  } mode_e;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] count;
  } cfg_t;

  function automatic logic [CNT_W-1:0] used_count(input logic [COUNT_W-1:0] c);
    logic [CNT_W-1:0] n;
    if (c == '0) begin
      n = CNT_W'(1);
    end else if (32'(c) > MAX_CATEGORIES) begin
      n = CNT_W'(MAX_CATEGORIES);
    end else begin
      n = CNT_W'(c);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hdl/wcs_ram.sv
// wcs_ram: generic single write, single read port ram with registered read
// no dependencies
`default_nettype none

module wcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/wcs_alu.sv
// wcs_alu: shared saturating adder and magnitude compare of the sampler
// depends on wcs_pkg
`default_nettype none

module wcs_alu
  import wcs_pkg::*;
(
  input  wire logic [DATA_W-1:0] add_a_i,
  input  wire logic [DATA_W-1:0] add_b_i,
  input  wire logic              cmp_sum_i,
  input  wire logic [DATA_W-1:0] cmp_x_i,
  input  wire logic [DATA_W-1:0] cmp_y_i,
  output logic      [DATA_W-1:0] sum_o,
  output logic                   gt_o
);

  logic [DATA_W:0]   sum_wide;
  logic [DATA_W-1:0] lhs;

  always_comb begin
    sum_wide = {1'b0, add_a_i} + {1'b0, add_b_i};
    sum_o    = sum_wide[DATA_W] ? '1 : sum_wide[DATA_W-1:0];
    lhs      = cmp_sum_i ? sum_o : cmp_x_i;
    gt_o     = lhs > cmp_y_i;
  end

endmodule

`default_nettype wire

>>> hdl/wcs_seq.sv
// wcs_seq: sampling sequencer, walks the tables one read a cycle through wcs_alu
// depends on wcs_pkg and wcs_alu
`default_nettype none

module wcs_seq
  import wcs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [OPCODE_W-1:0] opcode_i,
  input  wire logic [DATA_W-1:0]   random_fraction_i,
  input  wire logic                weights_given_i,
  input  wire cfg_t                cfg_i,
  output logic      [IDX_W-1:0]    rd_addr_o,
  input  wire logic [DATA_W-1:0]   cum_rdata_i,
  input  wire logic [DATA_W-1:0]   wgt_rdata_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [IDX_W-1:0]    chosen_index_o,
  output logic                     used_fallback_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MUL,
    S_SCAN,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   n_q;
  logic               pend_q;
  logic [IDX_W-1:0]   didx_q;
  logic [DATA_W-1:0]  acc_q;
  logic [DATA_W-1:0]  frac_q;
  logic [DATA_W-1:0]  prod_hi_q;
  logic               track_q;
  logic [IDX_W-1:0]   res_idx_q;
  logic               res_fb_q;
  logic               out_valid_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic               out_fb_q;

  logic               issue;
  logic [DATA_W-1:0]  rdata;
  logic [DATA_W-1:0]  sum;
  logic               gt;
  logic [2*DATA_W-1:0] prod;
  logic [CNT_W-1:0]   last_idx;

  assign in_ready_o      = state_q == S_IDLE;
  assign out_valid_o     = out_valid_q;
  assign chosen_index_o  = out_idx_q;
  assign used_fallback_o = out_fb_q;

  assign issue     = (state_q == S_SUM || state_q == S_SCAN) && cnt_q < n_q;
  assign rd_addr_o = cnt_q[IDX_W-1:0];
  assign rdata     = track_q ? wgt_rdata_i : cum_rdata_i;
  assign prod      = {{DATA_W{1'b0}}, frac_q} * {{DATA_W{1'b0}}, acc_q};
  assign last_idx  = n_q - CNT_W'(1);

  wcs_alu u_alu (
    .add_a_i   (acc_q),
    .add_b_i   (rdata),
    .cmp_sum_i (track_q),
    .cmp_x_i   (rdata),
    .cmp_y_i   (track_q ? prod_hi_q : frac_q),
    .sum_o     (sum),
    .gt_o      (gt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      track_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && opcode_i == OP_SAMPLE) begin
            frac_q <= random_fraction_i;
            n_q    <= used_count(cfg_i.count);
            cnt_q  <= '0;
            pend_q <= 1'b0;
            acc_q  <= '0;
            if (cfg_i.mode == MODE_INIT || (cfg_i.mode == MODE_TRACK && !weights_given_i)) begin
              track_q <= 1'b0;
              state_q <= S_SCAN;
            end else if (cfg_i.mode == MODE_TRACK) begin
              track_q <= 1'b1;
              state_q <= S_SUM;
            end else begin
              res_idx_q <= '0;
              res_fb_q  <= 1'b0;
              state_q   <= S_DONE;
            end
          end
        end
        S_SUM: begin
          pend_q <= issue;
          cnt_q  <= cnt_q + CNT_W'(issue);
          if (pend_q) begin
            acc_q <= sum;
          end
          if (!issue && !pend_q) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_hi_q <= prod[2*DATA_W-1:DATA_W];
          acc_q     <= '0;
          cnt_q     <= '0;
          pend_q    <= 1'b0;
          state_q   <= S_SCAN;
        end
        S_SCAN: begin
          pend_q <= issue;
          cnt_q  <= cnt_q + CNT_W'(issue);
          didx_q <= cnt_q[IDX_W-1:0];
          if (pend_q) begin
            acc_q <= sum;
          end
          if (pend_q && gt) begin
            res_idx_q <= didx_q;
            res_fb_q  <= 1'b0;
            state_q   <= S_DONE;
          end else if (!issue && !pend_q) begin
            res_idx_q <= track_q ? '0 : last_idx[IDX_W-1:0];
            res_fb_q  <= 1'b1;
            state_q   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= res_idx_q;
            out_fb_q    <= res_fb_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/weighted_category_sampler_core.sv
// weighted_category_sampler_core: top level with config registers and tables
// depends on wcs_pkg, wcs_ram and wcs_seq
//
// usage: items enter on the in_valid_i / in_ready_o channel. a write item
// (cumulative or weight entry) is stored in the cycle it is accepted, gives
// no result and leaves the block ready at once. a sample item gives one
// result on out_valid_o / out_ready_i.
// work of a sample, for n categories in use: the first index rule reads no
// table; the initial rule makes a scan pass over up to n entries; the
// tracking rule makes a summing pass, a multiply step and a scan pass.
// the passes read the tables entry by entry through one shared read
// address. in_ready_o is low while a sample is worked on and rises with
// out_valid_o. the result waits in an output register; loads are still
// taken while it waits, and a following sample finishes but holds until
// the receiver takes the earlier result.
// reset clears the sequencer and sets sampling_mode 0 and category_count 1;
// table contents stay undefined until written. registers sit at byte
// addresses 0 and 4 of the apb port; the user must write them only while
// idle, and the block itself does not enforce this.
`default_nettype none

module weighted_category_sampler_core
  import wcs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic      [PDATA_W-1:0]  prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [OPCODE_W-1:0] opcode_i,
  input  wire logic [ENTRY_W-1:0]  entry_index_i,
  input  wire logic [DATA_W-1:0]   entry_value_i,
  input  wire logic [DATA_W-1:0]   random_fraction_i,
  input  wire logic                weights_given_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [IDX_W-1:0]    chosen_index_o,
  output logic                     used_fallback_o
);

  cfg_t             cfg_q;
  logic             reg_idx;
  logic             in_acc;
  logic             entry_ok;
  logic             cum_we;
  logic             wgt_we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] rd_addr;
  logic [DATA_W-1:0] cum_rdata;
  logic [DATA_W-1:0] wgt_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= MODE_FIRST;
      cfg_q.count <= COUNT_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_MODE:  cfg_q.mode  <= pwdata[MODE_W-1:0];
        REG_COUNT: cfg_q.count <= pwdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:  prdata = PDATA_W'(cfg_q.mode);
      REG_COUNT: prdata = PDATA_W'(cfg_q.count);
      default:   prdata = '0;
    endcase
  end

  assign in_acc   = in_valid_i && in_ready_o;
  assign entry_ok = 32'(entry_index_i) < MAX_CATEGORIES;
  assign cum_we   = in_acc && entry_ok && opcode_i == OP_WR_CUM;
  assign wgt_we   = in_acc && entry_ok && opcode_i == OP_WR_WGT;
  assign waddr    = IDX_W'(entry_index_i);

  wcs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_CATEGORIES)
  ) u_cum_ram (
    .clk_i   (clk_i),
    .we_i    (cum_we),
    .waddr_i (waddr),
    .wdata_i (entry_value_i),
    .raddr_i (rd_addr),
    .rdata_o (cum_rdata)
  );

  wcs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_CATEGORIES)
  ) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (wgt_we),
    .waddr_i (waddr),
    .wdata_i (entry_value_i),
    .raddr_i (rd_addr),
    .rdata_o (wgt_rdata)
  );

  wcs_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .random_fraction_i (random_fraction_i),
    .weights_given_i   (weights_given_i),
    .cfg_i             (cfg_q),
    .rd_addr_o         (rd_addr),
    .cum_rdata_i       (cum_rdata),
    .wgt_rdata_i       (wgt_rdata),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .chosen_index_o    (chosen_index_o),
    .used_fallback_o   (used_fallback_o)
  );

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == OP_SAMPLE |=> !in_ready_o)
    else $error("sample accepted but block stayed ready");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result issued while sequencer busy");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> CNT_W'(chosen_index_o) < used_count(cfg_q.count))
    else $error("chosen index beyond categories in use");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == OP_WR_CUM || opcode_i == OP_WR_WGT)
    |=> in_ready_o)
    else $error("load item left block busy");

endmodule

`default_nettype wire
